// File: rtl/core/humidity_sensor_frame_check_convert_core_assert.svh
// Assertion macros for the frame check / convert core.
// Both macros expect clk, and HSFC_ASSERT also rst_n, to be visible where used.
`ifndef HUMIDITY_SENSOR_FRAME_CHECK_CONVERT_CORE_ASSERT_SVH
`define HUMIDITY_SENSOR_FRAME_CHECK_CONVERT_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked check, off while reset is held
`define HSFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check, also active during reset
`define HSFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define HSFC_ASSERT(lbl, prop, msg)
`define HSFC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: rtl/core/hsfc_pkg.sv
`timescale 1ns / 1ps

package hsfc_pkg;

  // CRC-8 settings of the sensor
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Byte positions inside the six-byte frame
  localparam logic [2:0] POS_TEMP_HI  = 3'd0;
  localparam logic [2:0] POS_TEMP_LO  = 3'd1;
  localparam logic [2:0] POS_TEMP_CRC = 3'd2;
  localparam logic [2:0] POS_HUM_HI   = 3'd3;
  localparam logic [2:0] POS_HUM_LO   = 3'd4;
  localparam logic [2:0] POS_HUM_CRC  = 3'd5;

  // Status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_TEMP_BAD = 2'd1;
  localparam logic [1:0] STAT_HUM_BAD  = 2'd2;

  // Conversion constants, in hundredths
  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [13:0] HUM_SPAN    = 14'd10000;
  localparam logic [15:0] FULL_SCALE  = 16'hFFFF;

  // Checked frame handed from the assembler to the converter
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] temp_raw;
    logic [15:0] hum_raw;
  } frame_t;

  // One byte of CRC-8, MSB first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: rtl/core/hsfc_if.sv
`timescale 1ns / 1ps

// Byte word channel
interface hsfc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// Result word channel
interface hsfc_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [15:0]        temp_raw;
  logic [15:0]        hum_raw;
  logic signed [14:0] temp_centi;
  logic [13:0]        hum_centi;

  modport source (output valid, output status, output temp_raw, output hum_raw,
                  output temp_centi, output hum_centi, input ready);
  modport sink   (input valid, input status, input temp_raw, input hum_raw,
                  input temp_centi, input hum_centi, output ready);
endinterface

// File: rtl/core/hsfc_frame.sv
`timescale 1ns / 1ps
`include "humidity_sensor_frame_check_convert_core_assert.svh"

module hsfc_frame (
  input  logic              clk,
  input  logic              rst_n,
  hsfc_byte_if.sink         in_ch,
  output hsfc_pkg::frame_t  frm_o,
  output logic              frm_valid_o,
  input  logic              frm_ready_i
);
  import hsfc_pkg::*;

  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] temp_word_r, temp_word_nxt;
  logic        temp_bad_r, temp_bad_nxt;
  logic [7:0]  hum_hi_r, hum_hi_nxt;
  logic [7:0]  hum_lo_r, hum_lo_nxt;
  frame_t      frm_r, frm_nxt;
  logic        frm_valid_r, frm_valid_nxt;

  logic       acc;
  logic [2:0] pos_eff;
  logic       last_byte;
  logic       hum_bad;

  // Frame register is free or drains this cycle
  assign in_ch.ready = !frm_valid_r || frm_ready_i;
  assign acc         = in_ch.valid && in_ch.ready;

  // Start flag or a stray code restarts at the temperature high byte
  assign pos_eff   = (in_ch.frame_start || pos_r > POS_HUM_CRC) ? POS_TEMP_HI : pos_r;
  assign last_byte = (pos_eff == POS_HUM_CRC);
  assign hum_bad   = (crc_r != in_ch.rx_byte);

  // Byte sequencing and CRC
  always_comb begin
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    temp_word_nxt = temp_word_r;
    temp_bad_nxt  = temp_bad_r;
    hum_hi_nxt    = hum_hi_r;
    hum_lo_nxt    = hum_lo_r;
    if (acc) begin
      case (pos_eff)
        POS_TEMP_HI: begin
          temp_word_nxt = {in_ch.rx_byte, 8'h00};
          crc_nxt       = crc8_update(CRC_INIT, in_ch.rx_byte);
          pos_nxt       = POS_TEMP_LO;
        end
        POS_TEMP_LO: begin
          temp_word_nxt = {temp_word_r[15:8], in_ch.rx_byte};
          crc_nxt       = crc8_update(crc_r, in_ch.rx_byte);
          pos_nxt       = POS_TEMP_CRC;
        end
        POS_TEMP_CRC: begin
          temp_bad_nxt = (crc_r != in_ch.rx_byte);
          crc_nxt      = CRC_INIT;
          pos_nxt      = POS_HUM_HI;
        end
        POS_HUM_HI: begin
          hum_hi_nxt = in_ch.rx_byte;
          crc_nxt    = crc8_update(crc_r, in_ch.rx_byte);
          pos_nxt    = POS_HUM_LO;
        end
        POS_HUM_LO: begin
          hum_lo_nxt = in_ch.rx_byte;
          crc_nxt    = crc8_update(crc_r, in_ch.rx_byte);
          pos_nxt    = POS_HUM_CRC;
        end
        default: begin
          crc_nxt = CRC_INIT;
          pos_nxt = POS_TEMP_HI;
        end
      endcase
    end
  end

  // Completed frame into the output register
  always_comb begin
    frm_nxt          = frm_r;
    frm_valid_nxt    = frm_valid_r && !frm_ready_i;
    if (acc && last_byte) begin
      frm_valid_nxt    = 1'b1;
      frm_nxt.temp_raw = temp_word_r;
      frm_nxt.hum_raw  = {hum_hi_r, hum_lo_r};
      frm_nxt.status   = temp_bad_r ? STAT_TEMP_BAD : (hum_bad ? STAT_HUM_BAD : STAT_OK);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_TEMP_HI;
      crc_r       <= CRC_INIT;
      frm_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      frm_valid_r <= frm_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    temp_word_r <= temp_word_nxt;
    temp_bad_r  <= temp_bad_nxt;
    hum_hi_r    <= hum_hi_nxt;
    hum_lo_r    <= hum_lo_nxt;
    frm_r       <= frm_nxt;
  end

  assign frm_o       = frm_r;
  assign frm_valid_o = frm_valid_r;

  // Checks
  `HSFC_ASSERT(a_start_restarts, acc && in_ch.frame_start |=> pos_r == POS_TEMP_LO,
    "start byte did not restart the frame")
  `HSFC_ASSERT(a_pos_range, pos_r <= POS_HUM_CRC, "byte position out of range")
  `HSFC_ASSERT(a_frame_from_last,
    $rose(frm_valid_r) |-> $past(acc && !in_ch.frame_start && pos_r == POS_HUM_CRC),
    "frame emitted without a sixth byte")
  `HSFC_ASSERT(a_crc_reseed, acc && pos_eff == POS_TEMP_CRC |=> crc_r == CRC_INIT,
    "CRC not reseeded after temperature check byte")
  `HSFC_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !frm_valid_r && pos_r == POS_TEMP_HI,
    "reset did not clear frame state")

endmodule

// File: rtl/core/hsfc_conv.sv
`timescale 1ns / 1ps

module hsfc_conv (
  input  logic              clk,
  input  logic              rst_n,
  input  hsfc_pkg::frame_t  frm_i,
  input  logic              frm_valid_i,
  output logic              frm_ready_o,
  hsfc_result_if.source     out_ch
);
  import hsfc_pkg::*;

  // Product stage
  logic        m_valid_r, m_valid_nxt;
  frame_t      m_frm_r;
  logic [30:0] m_tprod_r;
  logic [29:0] m_hprod_r;

  // Output stage
  logic               o_valid_r, o_valid_nxt;
  frame_t             o_frm_r;
  logic signed [14:0] o_tc_r, o_tc_nxt;
  logic [13:0]        o_hc_r, o_hc_nxt;

  logic o_adv, m_load;

  // x / 65535: q0 = x >> 16, remainder q0 + x[15:0] stays below 2*65535
  logic [14:0] t_q0, t_q, t_diff;
  logic [16:0] t_r0;
  logic [13:0] h_q0, h_q;
  logic [16:0] h_r0;

  assign o_adv       = !o_valid_r || out_ch.ready;
  assign frm_ready_o = !m_valid_r || o_adv;
  assign m_load      = frm_valid_i && frm_ready_o;

  assign m_valid_nxt = m_load || (m_valid_r && !o_adv);
  assign o_valid_nxt = (m_valid_r && o_adv) || (o_valid_r && !out_ch.ready);

  // Reciprocal correction and offset; zero readings unless status is OK
  always_comb begin
    t_q0   = m_tprod_r[30:16];
    t_r0   = {1'b0, m_tprod_r[15:0]} + {2'b00, t_q0};
    t_q    = t_q0 + {14'd0, (t_r0 >= {1'b0, FULL_SCALE})};
    t_diff = t_q - TEMP_OFFSET;
    h_q0   = m_hprod_r[29:16];
    h_r0   = {1'b0, m_hprod_r[15:0]} + {3'b000, h_q0};
    h_q    = h_q0 + {13'd0, (h_r0 >= {1'b0, FULL_SCALE})};
    if (m_frm_r.status == STAT_OK) begin
      o_tc_nxt = $signed(t_diff);
      o_hc_nxt = h_q;
    end else begin
      o_tc_nxt = '0;
      o_hc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      m_valid_r <= m_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (m_load) begin
      m_frm_r   <= frm_i;
      m_tprod_r <= 31'(TEMP_SPAN) * 31'(frm_i.temp_raw);
      m_hprod_r <= 30'(HUM_SPAN) * 30'(frm_i.hum_raw);
    end
    if (m_valid_r && o_adv) begin
      o_frm_r <= m_frm_r;
      o_tc_r  <= o_tc_nxt;
      o_hc_r  <= o_hc_nxt;
    end
  end

  assign out_ch.valid      = o_valid_r;
  assign out_ch.status     = o_frm_r.status;
  assign out_ch.temp_raw   = o_frm_r.temp_raw;
  assign out_ch.hum_raw    = o_frm_r.hum_raw;
  assign out_ch.temp_centi = o_tc_r;
  assign out_ch.hum_centi  = o_hc_r;

endmodule

// File: rtl/core/humidity_sensor_frame_check_convert_core.sv
`timescale 1ns / 1ps
// Frame check and convert core for a six-byte temperature / humidity reply.
// in_ch takes one byte word per cycle while ready is high: temperature
// high, low, CRC, then humidity high, low, CRC. frame_start on a byte drops
// any partial frame and takes that byte as the temperature high byte. Each
// word is checked with CRC-8 (poly 0x31, seed 0xFF). out_ch gives one word
// per frame: status, both raw words and both readings in hundredths (zero on
// a CRC failure). Throughput: one byte per cycle, sustained while out_ch is
// not stalled; the CRC update is one byte per cycle of combinational logic in
// the assembler. The sixth byte loads the frame register; the frame then
// passes the product and output registers, where the result becomes valid.
// Reset clears the byte position, reseeds the CRC and empties all stages.
// When the receiver stalls, the three stages fill and hold; in_ch.ready stays
// high while any stage is free, then drops until out_ch drains.
module humidity_sensor_frame_check_convert_core (
  input  logic          clk,
  input  logic          rst_n,
  hsfc_byte_if.sink     in_ch,
  hsfc_result_if.source out_ch
);
  import hsfc_pkg::*;

  frame_t frm;
  logic   frm_valid;
  logic   frm_ready;

  // Byte assembly and CRC check
  hsfc_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .frm_o       (frm),
    .frm_valid_o (frm_valid),
    .frm_ready_i (frm_ready)
  );

  // Fixed-point conversion
  hsfc_conv u_conv (
    .clk         (clk),
    .rst_n       (rst_n),
    .frm_i       (frm),
    .frm_valid_i (frm_valid),
    .frm_ready_o (frm_ready),
    .out_ch      (out_ch)
  );

endmodule

// File: dv/hsfc_tb_pkg.sv
`timescale 1ns / 1ps

package hsfc_tb_pkg;

  import hsfc_pkg::*;

  // One result word as the checker expects it
  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        temp_raw;
    logic [15:0]        hum_raw;
    logic signed [14:0] temp_centi;
    logic [13:0]        hum_centi;
  } reading_t;

  // CRC-8 over one byte, fed one data bit at a time, MSB first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] acc;
    logic       fb;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[7] ^ data[i];
      acc = {acc[6:0], 1'b0};
      if (fb) acc = acc ^ CRC_POLY;
    end
    return acc;
  endfunction

  // Check byte the sensor sends after a two-byte word
  function automatic logic [7:0] word_crc(input logic [15:0] w);
    return crc8_step(crc8_step(CRC_INIT, w[15:8]), w[7:0]);
  endfunction

endpackage

// File: dv/humidity_sensor_frame_check_convert_checker.sv
`timescale 1ns / 1ps

module humidity_sensor_frame_check_convert_checker (
  input  logic   clk,
  input  logic   rst_n,
  hsfc_byte_if   byte_mon,
  hsfc_result_if result_mon,
  output int     fail_count,
  output int     results_pending
);
  import hsfc_pkg::*;
  import hsfc_tb_pkg::*;

  // Frame assembler state, mirrors the block
  logic [2:0]  frame_pos;
  logic [7:0]  crc_acc;
  logic [15:0] temp_word;
  logic        temp_bad;
  logic [7:0]  hum_hi;
  logic [7:0]  hum_lo;

  reading_t expected_readings[$];
  int       mismatches;

  initial begin
    mismatches = 0;
  end

  // Build the reading that closes a frame on its humidity CRC byte
  function automatic reading_t close_frame(input logic [7:0] hum_crc_byte);
    reading_t    r;
    logic [31:0] q;
    r.temp_raw   = temp_word;
    r.hum_raw    = {hum_hi, hum_lo};
    r.status     = temp_bad ? STAT_TEMP_BAD :
                   (crc_acc != hum_crc_byte) ? STAT_HUM_BAD : STAT_OK;
    r.temp_centi = '0;
    r.hum_centi  = '0;
    if (r.status == STAT_OK) begin
      q            = (32'(TEMP_SPAN) * 32'(r.temp_raw)) / 32'(FULL_SCALE);
      r.temp_centi = 15'(int'(q) - int'(TEMP_OFFSET));
      q            = (32'(HUM_SPAN) * 32'(r.hum_raw)) / 32'(FULL_SCALE);
      r.hum_centi  = 14'(q);
    end
    return r;
  endfunction

  // Predict on accepted byte words, compare accepted result words
  always @(posedge clk) begin
    logic [2:0] pos;
    logic [7:0] b;
    reading_t   want;
    if (!rst_n) begin
      frame_pos = POS_TEMP_HI;
      crc_acc   = CRC_INIT;
      temp_word = '0;
      temp_bad  = 1'b0;
      hum_hi    = '0;
      hum_lo    = '0;
      expected_readings.delete();
    end else begin
      if (byte_mon.valid && byte_mon.ready) begin
        b   = byte_mon.rx_byte;
        // start flag or a stray position restarts the frame
        pos = (byte_mon.frame_start || frame_pos > POS_HUM_CRC) ? POS_TEMP_HI : frame_pos;
        case (pos)
          POS_TEMP_HI: begin
            temp_word = {b, 8'h00};
            crc_acc   = crc8_step(CRC_INIT, b);
            frame_pos = POS_TEMP_LO;
          end
          POS_TEMP_LO: begin
            temp_word[7:0] = b;
            crc_acc        = crc8_step(crc_acc, b);
            frame_pos      = POS_TEMP_CRC;
          end
          POS_TEMP_CRC: begin
            temp_bad  = (crc_acc != b);
            crc_acc   = CRC_INIT;
            frame_pos = POS_HUM_HI;
          end
          POS_HUM_HI: begin
            hum_hi    = b;
            crc_acc   = crc8_step(crc_acc, b);
            frame_pos = POS_HUM_LO;
          end
          POS_HUM_LO: begin
            hum_lo    = b;
            crc_acc   = crc8_step(crc_acc, b);
            frame_pos = POS_HUM_CRC;
          end
          default: begin
            expected_readings.push_back(close_frame(b));
            frame_pos = POS_TEMP_HI;
            crc_acc   = CRC_INIT;
          end
        endcase
      end

      if (result_mon.valid && result_mon.ready) begin
        if (expected_readings.size() == 0) begin
          $error("result word with no frame outstanding: status %0d temp_raw %0h hum_raw %0h",
                 result_mon.status, result_mon.temp_raw, result_mon.hum_raw);
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          if (result_mon.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, result_mon.status);
            mismatches++;
          end
          if (result_mon.temp_raw !== want.temp_raw) begin
            $error("temp_raw: expected %0h, actual %0h", want.temp_raw, result_mon.temp_raw);
            mismatches++;
          end
          if (result_mon.hum_raw !== want.hum_raw) begin
            $error("hum_raw: expected %0h, actual %0h", want.hum_raw, result_mon.hum_raw);
            mismatches++;
          end
          if (result_mon.temp_centi !== want.temp_centi) begin
            $error("temp_centi: expected %0d, actual %0d",
                   $signed(want.temp_centi), $signed(result_mon.temp_centi));
            mismatches++;
          end
          if (result_mon.hum_centi !== want.hum_centi) begin
            $error("hum_centi: expected %0d, actual %0d", want.hum_centi, result_mon.hum_centi);
            mismatches++;
          end
        end
      end
    end
    fail_count      <= mismatches;
    results_pending <= expected_readings.size();
  end

endmodule

// File: dv/humidity_sensor_frame_check_convert_core_tb.sv
`timescale 1ns / 1ps

module humidity_sensor_frame_check_convert_core_tb;

  import hsfc_tb_pkg::*;

  localparam int NUM_BYTES      = 550;
  localparam int LONG_STALL     = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;

  logic clk;
  logic rst_n;

  hsfc_byte_if   byte_ch ();
  hsfc_result_if result_ch ();

  int fail_count;
  int results_pending;
  int bytes_sent;
  int src_idle_pct;
  int sink_stall_pct;
  int stall_requests;
  int stalls_served;
  int idle_cycles;

  humidity_sensor_frame_check_convert_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (byte_ch),
    .out_ch (result_ch)
  );

  humidity_sensor_frame_check_convert_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .byte_mon        (byte_ch),
    .result_mon      (result_ch),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Watchdog: too long with no word moving on either side
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result receiver: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int stall_left;
    stall_left    = 0;
    stalls_served = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_requests != stalls_served) begin
        stalls_served++;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= rst_n && ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Offer one byte word, with random gaps, until it is taken
  task automatic send_byte(input logic [7:0] b, input logic st);
    while ($urandom_range(99) < src_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.rx_byte     <= b;
    byte_ch.frame_start <= st;
    do @(posedge clk); while (!byte_ch.ready);
    bytes_sent++;
  endtask

  // Full frame; a bad CRC is forced off the correct value
  task automatic send_frame(input logic [15:0] t, input logic [15:0] h, input logic st,
                            input logic t_ok, input logic h_ok);
    logic [7:0] t_crc;
    logic [7:0] h_crc;
    t_crc = word_crc(t);
    h_crc = word_crc(h);
    if (!t_ok) t_crc = t_crc ^ 8'($urandom_range(1, 255));
    if (!h_ok) h_crc = h_crc ^ 8'($urandom_range(1, 255));
    send_byte(t[15:8], st);
    send_byte(t[7:0], 1'b0);
    send_byte(t_crc, 1'b0);
    send_byte(h[15:8], 1'b0);
    send_byte(h[7:0], 1'b0);
    send_byte(h_crc, 1'b0);
  endtask

  // Random raw reading, extremes now and then
  function automatic logic [15:0] pick_raw();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // Lower valid and hold until every frame result is back
  task automatic drain();
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
  endtask

  initial begin : stimulus
    bit paused;
    int n;
    paused         = 1'b0;
    bytes_sent     = 0;
    stall_requests = 0;
    src_idle_pct   = 20;
    sink_stall_pct = 88;
    rst_n               <= 1'b0;
    byte_ch.valid       <= 1'b0;
    byte_ch.rx_byte     <= '0;
    byte_ch.frame_start <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: first frame carries no start flag, low extremes
    send_frame(16'h0000, 16'h0000, 1'b0, 1'b1, 1'b1);
    // high extremes
    send_frame(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    // restart just before the humidity CRC byte
    send_byte(8'h12, 1'b1);
    send_byte(8'h34, 1'b0);
    send_byte(word_crc(16'h1234), 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b0);
    // humidity CRC bad only
    send_frame(16'h6666, 16'h8000, 1'b1, 1'b1, 1'b0);
    // both CRCs bad: temperature failure wins
    send_frame(16'h7FFF, 16'h0001, 1'b1, 1'b0, 1'b0);

    // Random part: mostly well-formed frames, some cut short, some noise
    while (bytes_sent < NUM_BYTES) begin
      if (bytes_sent < NUM_BYTES / 3) begin
        src_idle_pct   = 20;
        sink_stall_pct = 88;
      end else if (bytes_sent < 2 * NUM_BYTES / 3) begin
        src_idle_pct   = 88;
        sink_stall_pct = 20;
      end else begin
        if (src_idle_pct != 0) stall_requests++;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end

      if (!paused && bytes_sent >= 100) begin
        paused = 1'b1;
        drain();
      end

      n = $urandom_range(99);
      if (n < 85) begin
        send_frame(pick_raw(), pick_raw(), 1'($urandom_range(1)),
                   $urandom_range(99) < 80, $urandom_range(99) < 80);
      end else if (n < 93) begin
        // frame cut short, then restarted with the flag
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom()), 1'b0);
        send_frame(pick_raw(), pick_raw(), 1'b1, 1'b1, 1'b1);
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom()), 1'($urandom_range(1)));
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_pending == 0) begin
      $display("All tests passed");
    end else begin
      if (results_pending != 0) $error("%0d frame results never arrived", results_pending);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/hsfc_pkg.sv
rtl/core/hsfc_if.sv
rtl/core/hsfc_frame.sv
rtl/core/hsfc_conv.sv
rtl/core/humidity_sensor_frame_check_convert_core.sv
dv/hsfc_tb_pkg.sv
dv/humidity_sensor_frame_check_convert_checker.sv
dv/humidity_sensor_frame_check_convert_core_tb.sv
